/* design/icc_pkg.sv */
// Shared types and constants for the reference-counted inode tag cache.
package icc_pkg;

  localparam int unsigned CACHE_ENTRIES = 64;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned IDX_W = $clog2(CACHE_ENTRIES);

  // Request codes on the func port.
  localparam logic [2:0] FUNC_GET = 3'd0;
  localparam logic [2:0] FUNC_PUT = 3'd1;
  localparam logic [2:0] FUNC_MARK_DIRTY = 3'd2;
  localparam logic [2:0] FUNC_MARK_DEAD = 3'd3;
  localparam logic [2:0] FUNC_INSERT = 3'd4;
  localparam logic [2:0] FUNC_CLEAR_ALL = 3'd5;

  // Result status codes.
  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_BAD_INODE = 2'd1;
  localparam logic [1:0] STAT_NO_SLOT = 2'd2;

  // One cache entry as it travels along the chain.
  typedef struct packed {
    logic [31:0]           tag;
    logic                  used;
    logic                  dead;
    logic                  dirty;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

endpackage

/* design/refcounted_inode_cache.sv */
// Top level: a rotating chain of entry cells driven by the scan sequencer.
// A get with a bad inode number, or an ignored request, answers in the cycle after
// acceptance; put, mark, insert and clear all take one chain turn (ST_APPLY).
// Any other get takes a lookup turn, a decision and an update turn, or ends after the
// decision when no slot can be claimed; one request at a time, busy high meanwhile.
// Results appear for one cycle with done; the receiver cannot stall.
// Synchronous reset clears every entry and the limit register at once; no clearing pass.
module refcounted_inode_cache (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [31:0] inode_number,
  input  logic [5:0]  slot_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [5:0]  slot_out,
  output logic        hit,
  output logic        load_needed,
  output logic        writeback_valid,
  output logic [31:0] writeback_inode,
  output logic        entry_dead
);

  icc_pkg::entry_t chain [icc_pkg::CACHE_ENTRIES];
  icc_pkg::entry_t feed;
  logic            shift_en;
  logic [31:0]     limit;

  // Limit register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // Chain of cells: each takes its upper neighbor, the last takes the rewritten head.
  for (genvar i = 0; i < icc_pkg::CACHE_ENTRIES; i++) begin : g_cell
    if (i == icc_pkg::CACHE_ENTRIES - 1) begin : g_tail
      icc_cell u_cell (
        .clk(clk), .rst(rst), .shift_en(shift_en), .ent_in(feed), .ent_q(chain[i])
      );
    end else begin : g_body
      icc_cell u_cell (
        .clk(clk), .rst(rst), .shift_en(shift_en), .ent_in(chain[i+1]), .ent_q(chain[i])
      );
    end
  end

  // Sequencer.
  icc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .inode_number(inode_number),
    .slot_index(slot_index),
    .limit(limit),
    .head(chain[0]),
    .feed(feed),
    .shift_en(shift_en),
    .done(done),
    .status(status),
    .slot_out(slot_out),
    .hit(hit),
    .load_needed(load_needed),
    .writeback_valid(writeback_valid),
    .writeback_inode(writeback_inode),
    .entry_dead(entry_dead)
  );

endmodule

/* design/icc_cell.sv */
// One storage cell of the rotating entry chain.
module icc_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift_en,
  input  icc_pkg::entry_t ent_in,
  output icc_pkg::entry_t ent_q
);

  // The cell takes its neighbor's entry whenever the chain moves.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_q <= '0;
    end else if (shift_en) begin
      ent_q <= ent_in;
    end
  end

endmodule

/* design/icc_ctrl.sv */
// Sequencer that scans the chain head and rewrites entries at the chain tail.
module icc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             func,
  input  logic [31:0]            inode_number,
  input  logic [5:0]             slot_index,
  input  logic [31:0]            limit,
  input  icc_pkg::entry_t        head,
  output icc_pkg::entry_t        feed,
  output logic                   shift_en,
  output logic                   done,
  output logic [1:0]             status,
  output logic [5:0]             slot_out,
  output logic                   hit,
  output logic                   load_needed,
  output logic                   writeback_valid,
  output logic [31:0]            writeback_inode,
  output logic                   entry_dead
);

  localparam logic [icc_pkg::IDX_W-1:0] LAST_IDX = icc_pkg::IDX_W'(icc_pkg::CACHE_ENTRIES - 1);
  localparam logic [icc_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {ST_IDLE, ST_FIND, ST_DECIDE, ST_APPLY} state_t;
  typedef enum logic [2:0] {
    ACT_INC, ACT_CLAIM, ACT_PUT, ACT_DIRTY, ACT_DEAD, ACT_INSERT, ACT_CLEAR
  } act_t;

  state_t                        state;
  act_t                          act;
  logic [icc_pkg::IDX_W-1:0]     pos;
  logic [icc_pkg::IDX_W-1:0]     target;
  logic [31:0]                   ino;
  logic                          m_found, f_found, d_found, l_found;
  logic [icc_pkg::IDX_W-1:0]     m_idx, f_idx, d_idx, l_idx;
  logic                          l_dirty;
  logic [31:0]                   l_tag;

  logic                          accept;
  logic                          bad_inode;
  logic                          slot_ok;
  logic                          at_target;
  logic                          put_wb;
  logic [icc_pkg::COUNT_BITS-1:0] put_count;
  logic                          is_match, is_free, is_deadz, is_livez;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;
  assign shift_en = (state == ST_FIND) || (state == ST_APPLY);
  assign bad_inode = (inode_number == 32'd0) || ((limit != 32'd0) && (inode_number > limit));
  assign slot_ok = (32'(slot_index) < 32'(icc_pkg::CACHE_ENTRIES));
  assign at_target = (pos == target);

  // Classification of the entry at the chain head during a lookup.
  assign is_match = head.used && !head.dead && (head.tag == ino);
  assign is_free = !head.used;
  assign is_deadz = head.used && head.dead && (head.count == '0);
  assign is_livez = head.used && (head.count == '0);

  // Rewrite of the head entry on its way back into the tail cell.
  always_comb begin
    feed = head;
    put_wb = 1'b0;
    put_count = (head.count != '0) ? head.count - 1'b1 : head.count;
    if (state == ST_APPLY) begin
      if (act == ACT_CLEAR) begin
        feed.used = 1'b0;
        feed.dead = 1'b0;
        feed.count = '0;
      end else if (at_target) begin
        case (act)
          ACT_INC: begin
            if (head.count != COUNT_MAX) feed.count = head.count + 1'b1;
          end
          ACT_CLAIM: begin
            feed.tag = ino;
            feed.count = icc_pkg::COUNT_BITS'(1);
            feed.used = 1'b1;
            feed.dead = 1'b0;
            feed.dirty = 1'b0;
          end
          ACT_PUT: begin
            feed.count = put_count;
            if (put_count == '0) begin
              if (head.dead) begin
                feed.used = 1'b0;
              end else if (head.dirty) begin
                feed.dirty = 1'b0;
                put_wb = 1'b1;
              end
            end
          end
          ACT_DIRTY: feed.dirty = 1'b1;
          ACT_DEAD: feed.dead = 1'b1;
          ACT_INSERT: begin
            feed.tag = ino;
            feed.used = 1'b1;
            feed.dead = 1'b0;
          end
          default: feed = head;
        endcase
      end
    end
  end

  // Sequencer state, scan bookkeeping and the result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      act <= ACT_INC;
      pos <= '0;
      target <= '0;
      done <= 1'b0;
      m_found <= 1'b0;
      f_found <= 1'b0;
      d_found <= 1'b0;
      l_found <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            ino <= inode_number;
            target <= icc_pkg::IDX_W'(slot_index);
            pos <= '0;
            status <= icc_pkg::STAT_OK;
            slot_out <= '0;
            hit <= 1'b0;
            load_needed <= 1'b0;
            writeback_valid <= 1'b0;
            writeback_inode <= '0;
            entry_dead <= 1'b0;
            m_found <= 1'b0;
            f_found <= 1'b0;
            d_found <= 1'b0;
            l_found <= 1'b0;
            unique case (func)
              icc_pkg::FUNC_GET: begin
                if (bad_inode) begin
                  status <= icc_pkg::STAT_BAD_INODE;
                  done <= 1'b1;
                end else begin
                  state <= ST_FIND;
                end
              end
              icc_pkg::FUNC_PUT, icc_pkg::FUNC_MARK_DIRTY,
              icc_pkg::FUNC_MARK_DEAD, icc_pkg::FUNC_INSERT: begin
                if (slot_ok) begin
                  state <= ST_APPLY;
                end else begin
                  done <= 1'b1;
                end
                unique case (func)
                  icc_pkg::FUNC_PUT: act <= ACT_PUT;
                  icc_pkg::FUNC_MARK_DIRTY: act <= ACT_DIRTY;
                  icc_pkg::FUNC_MARK_DEAD: act <= ACT_DEAD;
                  default: act <= ACT_INSERT;
                endcase
              end
              icc_pkg::FUNC_CLEAR_ALL: begin
                act <= ACT_CLEAR;
                state <= ST_APPLY;
              end
              default: done <= 1'b1;
            endcase
          end
        end

        ST_FIND: begin
          // Keep the lowest index of each candidate class.
          if (is_match && !m_found) begin
            m_found <= 1'b1;
            m_idx <= pos;
          end
          if (is_free && !f_found) begin
            f_found <= 1'b1;
            f_idx <= pos;
          end
          if (is_deadz && !d_found) begin
            d_found <= 1'b1;
            d_idx <= pos;
          end
          if (is_livez && !l_found) begin
            l_found <= 1'b1;
            l_idx <= pos;
            l_dirty <= head.dirty;
            l_tag <= head.tag;
          end
          if (pos == LAST_IDX) begin
            pos <= '0;
            state <= ST_DECIDE;
          end else begin
            pos <= pos + 1'b1;
          end
        end

        ST_DECIDE: begin
          // Hit first, then free slot, dead idle entry, live idle entry.
          state <= ST_APPLY;
          if (m_found) begin
            act <= ACT_INC;
            target <= m_idx;
            slot_out <= 6'(m_idx);
            hit <= 1'b1;
          end else if (f_found) begin
            act <= ACT_CLAIM;
            target <= f_idx;
            slot_out <= 6'(f_idx);
            load_needed <= 1'b1;
          end else if (d_found) begin
            act <= ACT_CLAIM;
            target <= d_idx;
            slot_out <= 6'(d_idx);
            load_needed <= 1'b1;
          end else if (l_found) begin
            act <= ACT_CLAIM;
            target <= l_idx;
            slot_out <= 6'(l_idx);
            load_needed <= 1'b1;
            writeback_valid <= l_dirty;
            writeback_inode <= l_dirty ? l_tag : 32'd0;
          end else begin
            status <= icc_pkg::STAT_NO_SLOT;
            done <= 1'b1;
            state <= ST_IDLE;
          end
        end

        ST_APPLY: begin
          if (at_target && act != ACT_CLEAR) begin
            entry_dead <= feed.dead;
            if (put_wb) begin
              writeback_valid <= 1'b1;
              writeback_inode <= head.tag;
            end
          end
          if (pos == LAST_IDX) begin
            pos <= '0;
            done <= 1'b1;
            state <= ST_IDLE;
          end else begin
            pos <= pos + 1'b1;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/icc_checker.sv */
// Port-level checks for the inode tag cache, bound to the top level.
module icc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [2:0]  func,
  input logic        done,
  input logic [1:0]  status,
  input logic        hit,
  input logic        load_needed,
  input logic        writeback_valid,
  input logic        entry_dead
);

  // A result always closes the transaction it belongs to.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // The block only gets busy after accepting a request.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // Unknown codes answer at once.
  a_unknown_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func > icc_pkg::FUNC_CLEAR_ALL)) |=> (done && !busy))
    else $error("unknown request not answered in one cycle");

  // A hit neither loads nor fails.
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (status == icc_pkg::STAT_OK && !load_needed && !entry_dead))
    else $error("inconsistent hit result");

  // A failed request reports nothing else.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status != icc_pkg::STAT_OK) |-> (!hit && !load_needed && !writeback_valid))
    else $error("failed request reported side effects");

endmodule

bind refcounted_inode_cache icc_checker u_icc_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .func(func),
  .done(done),
  .status(status),
  .hit(hit),
  .load_needed(load_needed),
  .writeback_valid(writeback_valid),
  .entry_dead(entry_dead)
);

/* sim/tb.sv */
// Self-checking testbench for the reference-counted inode tag cache.
module tb;

  // One response of the cache, field by field.
  typedef struct packed {
    logic [1:0]                status;
    logic [icc_pkg::IDX_W-1:0] slot;
    logic                      hit;
    logic                      load;
    logic                      wb_valid;
    logic [31:0]               wb_inode;
    logic                      dead;
  } cache_resp_t;

  // One row of the directed table; typed rows carry their own expected response.
  typedef struct packed {
    logic [2:0]                func;
    logic [31:0]               ino;
    logic [icc_pkg::IDX_W-1:0] slot;
    logic                      typed;
    cache_resp_t               resp;
  } request_row_t;

  localparam logic [icc_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [2:0] FUNC_UNUSED_A = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_B = 3'd7;
  localparam int NUM_PHASES = 5;
  localparam int PHASE_ITEMS = 340;
  localparam int FILL_ITEMS = 70;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  func = icc_pkg::FUNC_GET;
  logic [31:0] inode_number = '0;
  logic [5:0]  slot_index = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        done;
  logic [1:0]  status;
  logic [5:0]  slot_out;
  logic        hit;
  logic        load_needed;
  logic        writeback_valid;
  logic [31:0] writeback_inode;
  logic        entry_dead;

  // Shadow copy of the cache state and the limit register.
  logic [31:0]                    shadow_tag [icc_pkg::CACHE_ENTRIES];
  bit                             shadow_used [icc_pkg::CACHE_ENTRIES];
  bit                             shadow_dead [icc_pkg::CACHE_ENTRIES];
  bit                             shadow_dirty [icc_pkg::CACHE_ENTRIES];
  logic [icc_pkg::COUNT_BITS-1:0] shadow_count [icc_pkg::CACHE_ENTRIES];
  logic [31:0]                    shadow_limit;

  cache_resp_t  pending_responses [$];
  request_row_t directed_rows [$];
  int           errors = 0;
  int           requests_sent = 0;
  int           responses_seen = 0;
  int           hits_seen = 0;
  int           no_slot_seen = 0;
  int           writebacks_seen = 0;
  logic [31:0]  fresh_inode = 32'h0000_8000;

  refcounted_inode_cache DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .inode_number   (inode_number),
    .slot_index     (slot_index),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .done           (done),
    .status         (status),
    .slot_out       (slot_out),
    .hit            (hit),
    .load_needed    (load_needed),
    .writeback_valid(writeback_valid),
    .writeback_inode(writeback_inode),
    .entry_dead     (entry_dead)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reset image of the shadow state.
  function automatic void clear_shadow();
    int i;
    for (i = 0; i < icc_pkg::CACHE_ENTRIES; i++) begin
      shadow_tag[i] = '0;
      shadow_used[i] = 1'b0;
      shadow_dead[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_count[i] = '0;
    end
    shadow_limit = '0;
  endfunction

  function automatic cache_resp_t make_resp(logic [1:0] st, logic [icc_pkg::IDX_W-1:0] sl,
                                            logic h, logic ld, logic wv, logic [31:0] wi,
                                            logic ed);
    cache_resp_t r;
    r.status = st;
    r.slot = sl;
    r.hit = h;
    r.load = ld;
    r.wb_valid = wv;
    r.wb_inode = wi;
    r.dead = ed;
    return r;
  endfunction

  // Computes the response to one request and advances the shadow state.
  function automatic cache_resp_t predict_cache_response(logic [2:0] f, logic [31:0] ino,
                                                         logic [icc_pkg::IDX_W-1:0] sl);
    cache_resp_t r;
    int e;
    int i;
    r = '0;
    e = -1;
    case (f)
      icc_pkg::FUNC_GET: begin
        if (ino == 0 || (shadow_limit != 0 && ino > shadow_limit)) begin
          r.status = icc_pkg::STAT_BAD_INODE;
        end else begin
          // Lookup: lowest live entry with a matching tag.
          for (i = 0; i < icc_pkg::CACHE_ENTRIES; i++)
            if (e < 0 && shadow_used[i] && !shadow_dead[i] && shadow_tag[i] == ino) e = i;
          if (e >= 0) begin
            if (shadow_count[e] != COUNT_MAX) shadow_count[e] = shadow_count[e] + 1'b1;
            r.hit = 1'b1;
            r.slot = e[icc_pkg::IDX_W-1:0];
            r.dead = shadow_dead[e];
          end else begin
            // Victim order: free, then dead and idle, then live and idle.
            for (i = 0; i < icc_pkg::CACHE_ENTRIES; i++)
              if (e < 0 && !shadow_used[i]) e = i;
            for (i = 0; i < icc_pkg::CACHE_ENTRIES; i++)
              if (e < 0 && shadow_used[i] && shadow_dead[i] && shadow_count[i] == 0) e = i;
            for (i = 0; i < icc_pkg::CACHE_ENTRIES; i++)
              if (e < 0 && shadow_used[i] && shadow_count[i] == 0) begin
                e = i;
                if (shadow_dirty[i]) begin
                  r.wb_valid = 1'b1;
                  r.wb_inode = shadow_tag[i];
                end
              end
            if (e < 0) begin
              r.status = icc_pkg::STAT_NO_SLOT;
            end else begin
              shadow_tag[e] = ino;
              shadow_count[e] = icc_pkg::COUNT_BITS'(1);
              shadow_used[e] = 1'b1;
              shadow_dead[e] = 1'b0;
              shadow_dirty[e] = 1'b0;
              r.load = 1'b1;
              r.slot = e[icc_pkg::IDX_W-1:0];
            end
          end
        end
      end
      icc_pkg::FUNC_PUT: begin
        if (shadow_count[sl] != 0) shadow_count[sl] = shadow_count[sl] - 1'b1;
        if (shadow_count[sl] == 0) begin
          if (shadow_dead[sl]) begin
            shadow_used[sl] = 1'b0;
          end else if (shadow_dirty[sl]) begin
            r.wb_valid = 1'b1;
            r.wb_inode = shadow_tag[sl];
            shadow_dirty[sl] = 1'b0;
          end
        end
        r.dead = shadow_dead[sl];
      end
      icc_pkg::FUNC_MARK_DIRTY: begin
        shadow_dirty[sl] = 1'b1;
        r.dead = shadow_dead[sl];
      end
      icc_pkg::FUNC_MARK_DEAD: begin
        shadow_dead[sl] = 1'b1;
        r.dead = 1'b1;
      end
      icc_pkg::FUNC_INSERT: begin
        shadow_tag[sl] = ino;
        shadow_used[sl] = 1'b1;
        shadow_dead[sl] = 1'b0;
      end
      icc_pkg::FUNC_CLEAR_ALL: begin
        for (i = 0; i < icc_pkg::CACHE_ENTRIES; i++) begin
          shadow_used[i] = 1'b0;
          shadow_dead[i] = 1'b0;
          shadow_count[i] = '0;
        end
      end
      default: begin
        // Unused request codes leave everything as it was.
      end
    endcase
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Issues one request, waits for the transaction and records its expected response.
  task automatic send_request(logic [2:0] f, logic [31:0] ino, logic [icc_pkg::IDX_W-1:0] sl,
                              bit typed, cache_resp_t typed_resp, int gap);
    cache_resp_t predicted;
    start <= 1'b1;
    func <= f;
    inode_number <= ino;
    slot_index <= sl;
    do @(posedge clk); while (busy);
    predicted = predict_cache_response(f, ino, sl);
    pending_responses.push_back(typed ? typed_resp : predicted);
    requests_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets every outstanding response arrive and the block settle.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow_limit = value;
    cfg_valid <= 1'b0;
  endtask

  // Inode numbers: mostly a small pool that fits the limit, plus the edges.
  function automatic logic [31:0] pick_inode();
    int r;
    logic [31:0] pool_top;
    pool_top = (shadow_limit == 0 || shadow_limit > 96) ? 32'd96 : shadow_limit;
    r = $urandom_range(0, 99);
    if (r < 72) return $urandom_range(1, pool_top);
    if (r < 80) return 32'd0;
    if (r < 88) return $urandom;
    if (r < 94) return shadow_limit + $urandom_range(0, 1);
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic [2:0] pick_func();
    int r;
    r = $urandom_range(0, 999);
    if (r < 400) return icc_pkg::FUNC_GET;
    if (r < 720) return icc_pkg::FUNC_PUT;
    if (r < 790) return icc_pkg::FUNC_MARK_DIRTY;
    if (r < 850) return icc_pkg::FUNC_MARK_DEAD;
    if (r < 930) return icc_pkg::FUNC_INSERT;
    if (r < 945) return icc_pkg::FUNC_CLEAR_ALL;
    if (r < 953) return FUNC_UNUSED_A;
    if (r < 960) return FUNC_UNUSED_B;
    return icc_pkg::FUNC_GET;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // Response checker: every strobed response is matched against the oldest expectation.
  always @(posedge clk) begin
    cache_resp_t want;
    if (!rst && done) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected response: expected none, actual status %0h slot %0h",
                 $time, status, slot_out);
        errors++;
      end else begin
        want = pending_responses.pop_front();
        responses_seen++;
        if (want.hit) hits_seen++;
        if (want.status == icc_pkg::STAT_NO_SLOT) no_slot_seen++;
        if (want.wb_valid) writebacks_seen++;
        check_field("status", 32'(want.status), 32'(status));
        check_field("slot_out", 32'(want.slot), 32'(slot_out));
        check_field("hit", 32'(want.hit), 32'(hit));
        check_field("load_needed", 32'(want.load), 32'(load_needed));
        check_field("writeback_valid", 32'(want.wb_valid), 32'(writeback_valid));
        check_field("writeback_inode", want.wb_inode, writeback_inode);
        check_field("entry_dead", 32'(want.dead), 32'(entry_dead));
      end
    end
  end

  // Main sequence: reset, directed table, then random phases over several limits.
  initial begin
    request_row_t row;
    logic [31:0]  limits [NUM_PHASES];
    int n;
    int k;
    int fill_at;
    bit quiet;

    clear_shadow();
    limits[0] = 32'h0000_0100;
    limits[1] = 32'd1;
    limits[2] = 32'hFFFF_FFFF;
    limits[3] = $urandom | 32'h0001_0000;
    limits[4] = 32'd0;

    // Directed table, written against the reset state with no inode limit.
    // Count saturation takes 65535 hits on one entry, well beyond this run's length.
    directed_rows.push_back({icc_pkg::FUNC_GET, 32'd0, 6'd0, 1'b1,
                             make_resp(icc_pkg::STAT_BAD_INODE, 6'd0, 1'b0, 1'b0, 1'b0,
                                       32'd0, 1'b0)});
    directed_rows.push_back({icc_pkg::FUNC_GET, 32'd5, 6'd0, 1'b1,
                             make_resp(icc_pkg::STAT_OK, 6'd0, 1'b0, 1'b1, 1'b0,
                                       32'd0, 1'b0)});
    directed_rows.push_back({icc_pkg::FUNC_GET, 32'd5, 6'd0, 1'b1,
                             make_resp(icc_pkg::STAT_OK, 6'd0, 1'b1, 1'b0, 1'b0,
                                       32'd0, 1'b0)});
    directed_rows.push_back({icc_pkg::FUNC_GET, 32'hFFFF_FFFF, 6'd0, 1'b1,
                             make_resp(icc_pkg::STAT_OK, 6'd1, 1'b0, 1'b1, 1'b0,
                                       32'd0, 1'b0)});
    directed_rows.push_back({icc_pkg::FUNC_MARK_DIRTY, 32'd0, 6'd1, 1'b1,
                             make_resp(icc_pkg::STAT_OK, 6'd0, 1'b0, 1'b0, 1'b0,
                                       32'd0, 1'b0)});
    directed_rows.push_back({icc_pkg::FUNC_PUT, 32'd0, 6'd1, 1'b1,
                             make_resp(icc_pkg::STAT_OK, 6'd0, 1'b0, 1'b0, 1'b1,
                                       32'hFFFF_FFFF, 1'b0)});
    directed_rows.push_back({icc_pkg::FUNC_MARK_DEAD, 32'd0, 6'd0, 1'b1,
                             make_resp(icc_pkg::STAT_OK, 6'd0, 1'b0, 1'b0, 1'b0,
                                       32'd0, 1'b1)});
    // A dead entry no longer matches, so this get claims a new slot.
    directed_rows.push_back({icc_pkg::FUNC_GET, 32'd5, 6'd0, 1'b0, 44'd0});
    // Puts drain the dead entry until it is released.
    directed_rows.push_back({icc_pkg::FUNC_PUT, 32'd0, 6'd0, 1'b0, 44'd0});
    directed_rows.push_back({icc_pkg::FUNC_PUT, 32'd0, 6'd0, 1'b0, 44'd0});
    directed_rows.push_back({icc_pkg::FUNC_PUT, 32'd0, 6'd0, 1'b0, 44'd0});
    // Insert, then a duplicate tag at a lower slot that a get must prefer.
    directed_rows.push_back({icc_pkg::FUNC_INSERT, 32'd7, 6'd63, 1'b0, 44'd0});
    directed_rows.push_back({icc_pkg::FUNC_GET, 32'd7, 6'd0, 1'b0, 44'd0});
    directed_rows.push_back({icc_pkg::FUNC_PUT, 32'd0, 6'd63, 1'b0, 44'd0});
    directed_rows.push_back({icc_pkg::FUNC_INSERT, 32'd7, 6'd4, 1'b0, 44'd0});
    directed_rows.push_back({icc_pkg::FUNC_GET, 32'd7, 6'd0, 1'b0, 44'd0});
    directed_rows.push_back({FUNC_UNUSED_A, 32'd9, 6'd2, 1'b1,
                             make_resp(icc_pkg::STAT_OK, 6'd0, 1'b0, 1'b0, 1'b0,
                                       32'd0, 1'b0)});
    directed_rows.push_back({FUNC_UNUSED_B, 32'hFFFF_FFFF, 6'd63, 1'b1,
                             make_resp(icc_pkg::STAT_OK, 6'd0, 1'b0, 1'b0, 1'b0,
                                       32'd0, 1'b0)});
    directed_rows.push_back({icc_pkg::FUNC_MARK_DIRTY, 32'd0, 6'd63, 1'b0, 44'd0});
    directed_rows.push_back({icc_pkg::FUNC_CLEAR_ALL, 32'hFFFF_FFFF, 6'd63, 1'b1,
                             make_resp(icc_pkg::STAT_OK, 6'd0, 1'b0, 1'b0, 1'b0,
                                       32'd0, 1'b0)});
    directed_rows.push_back({icc_pkg::FUNC_GET, 32'd9, 6'd0, 1'b0, 44'd0});
    directed_rows.push_back({icc_pkg::FUNC_PUT, 32'd0, 6'd0, 1'b0, 44'd0});
    directed_rows.push_back({icc_pkg::FUNC_GET, 32'd1, 6'd0, 1'b0, 44'd0});

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.func, row.ino, row.slot, row.typed, row.resp, pick_gap(1'b0));
    end

    // Random phases, one per limit setting; each holds one burst of fresh gets meant to fill the
    // cache and force eviction and no-slot cases; under a limit of 1 most are bad inodes.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_limit(limits[p]);
      fill_at = $urandom_range(20, PHASE_ITEMS - FILL_ITEMS - 20);
      quiet = 1'b0;
      n = 0;
      while (n < PHASE_ITEMS) begin
        if (n % 40 == 0) quiet = ($urandom_range(0, 99) < 25);
        if (n == fill_at) begin
          for (k = 0; k < FILL_ITEMS; k++)
            send_request(icc_pkg::FUNC_GET,
                         (shadow_limit == 0 || shadow_limit >= 32'h0001_0000) ?
                           fresh_inode + k : k + 1,
                         icc_pkg::IDX_W'($urandom_range(0, icc_pkg::CACHE_ENTRIES - 1)),
                         1'b0, '0, pick_gap(quiet));
          fresh_inode = fresh_inode + FILL_ITEMS;
          n += FILL_ITEMS;
        end else begin
          send_request(pick_func(), pick_inode(),
                       icc_pkg::IDX_W'($urandom_range(0, icc_pkg::CACHE_ENTRIES - 1)),
                       1'b0, '0, pick_gap(quiet));
          n++;
        end
      end
    end

    // Drain: wait for the last responses, then a margin of one full get.
    start <= 1'b0;
    for (k = 0; k < 4000 && pending_responses.size() != 0; k++) @(posedge clk);
    repeat (2 * icc_pkg::CACHE_ENTRIES + 20) @(posedge clk);
    if (pending_responses.size() != 0) begin
      $display("%0t: %0d responses expected but never seen, oldest status %0h slot %0h",
               $time, pending_responses.size(), pending_responses[0].status,
               pending_responses[0].slot);
      errors += pending_responses.size();
    end

    $display("Sent %0d requests over %0d limit settings, checked %0d responses.",
             requests_sent, NUM_PHASES + 1, responses_seen);
    $display("Responses included %0d hits, %0d no-slot misses and %0d write-backs; %0d errors.",
             hits_seen, no_slot_seen, writebacks_seen, errors);
    if (errors == 0) begin
      $display("refcounted_inode_cache verification clean");
    end else begin
      $display("refcounted_inode_cache verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("Timeout with %0d responses outstanding.", pending_responses.size());
    $display("refcounted_inode_cache verification failed");
    $finish;
  end

endmodule
